>>> rtl/maidenhead_locator_encode_unit_defines.svh
// Assertion macros used by the locator encoder top level.
`ifndef MAIDENHEAD_LOCATOR_ENCODE_UNIT_DEFINES_SVH
`define MAIDENHEAD_LOCATOR_ENCODE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset.
`define MHL_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define MHL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MHL_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define MHL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

>>> rtl/mhl_pkg.sv
// Package with widths, constants, types and helpers of the locator encoder.
package mhl_pkg;

    localparam int LAT_W       = 31;
    localparam int LON_W       = 32;
    localparam int PREC_W      = 4;
    localparam int S_TDATA_W   = 72;
    localparam int M_TDATA_W   = 56;

    localparam longint LAT_SPAN   = 64'sd900000000;
    localparam longint LON_SPAN   = 64'sd1800000000;
    localparam longint LAT_SQUARE = 64'sd10000000;
    localparam longint LON_SQUARE = 64'sd20000000;

    localparam int SUB_DIV  = 24;
    localparam int EXT_DIV  = 10;
    // Subsquare and extended square together split one square into this many steps.
    localparam int FINE_DIV = SUB_DIV * EXT_DIV;

    localparam int IDX_W       = 8;
    localparam int AXIS_STAGES = 6;

    localparam logic [6:0] ASCII_UPPER_A = 7'd65;
    localparam logic [6:0] ASCII_LOWER_A = 7'd97;
    localparam logic [5:0] ASCII_ZERO    = 6'd48;

    localparam logic [PREC_W-1:0] PREC_SUB_MIN = 4'd5;
    localparam logic [PREC_W-1:0] PREC_EXT_MIN = 4'd7;

    localparam logic [3:0] COUNT_SHORT  = 4'd4;
    localparam logic [3:0] COUNT_MEDIUM = 4'd6;
    localparam logic [3:0] COUNT_FULL   = 4'd8;

    typedef struct packed {
        logic [AXIS_STAGES-1:0] load;
    } mhl_pipe_ctrl_t;

    typedef struct packed {
        logic [4:0] tens;
        logic [3:0] ones;
    } mhl_digits_t;

    // Splits an 8-bit value into tens and ones; 205/2048 is exact for that range.
    function automatic mhl_digits_t mhl_split10(input logic [IDX_W-1:0] v);
        logic [15:0]      p;
        logic [IDX_W-1:0] rest;
        mhl_digits_t      d;
        p      = 16'(v) * 16'd205;
        d.tens = p[15:11];
        rest   = v - IDX_W'(d.tens) * IDX_W'(4'd10);
        d.ones = rest[3:0];
        return d;
    endfunction

endpackage

>>> rtl/maidenhead_locator_encode_unit.sv
// Top level of the Maidenhead locator encoder: stream ports, pipeline control, output stage.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata: latitude, longitude, precision
//  m_      | out | m_tvalid/m_tready  | m_tdata: eight locator characters, char_count
//
//  One item enters per cycle while s_tready is high; each item passes through six axis
//  stages plus the output register, set by the two reciprocal-and-correct divisions.
//  aresetn is synchronous and active low; it clears only the stage and output valid bits.
//  A stall on m_tready fills empty stages first; s_tready drops only when every
//  stage holds an item and the output is stalled.
`include "maidenhead_locator_encode_unit_defines.svh"

module maidenhead_locator_encode_unit import mhl_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // latitude[30:0], longitude[62:31], precision[66:63], zero fill[71:67]
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // lon_field_letter[6:0], lat_field_letter[13:7], lon_square_digit[19:14],
    // lat_square_digit[25:20], lon_subsquare_letter[32:26],
    // lat_subsquare_letter[39:33], lon_extended_digit[45:40],
    // lat_extended_digit[51:46], char_count[55:52]
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic [AXIS_STAGES-1:0] valid_reg, valid_next;
    logic [AXIS_STAGES:0]   adv;
    logic [PREC_W-1:0]      prec_reg [AXIS_STAGES];
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;
    mhl_pipe_ctrl_t         ctrl;

    logic signed [LAT_W-1:0] lat_in;
    logic signed [LON_W-1:0] lon_in;
    logic [IDX_W-1:0]        lat_coarse, lat_fine, lon_coarse, lon_fine;
    mhl_digits_t             lat_cd, lat_fd, lon_cd, lon_fd;

    logic [6:0] lon_field_letter, lat_field_letter;
    logic [5:0] lon_square_digit, lat_square_digit;
    logic [6:0] lon_subsquare_letter, lat_subsquare_letter;
    logic [5:0] lon_extended_digit, lat_extended_digit;
    logic [3:0] char_count;

    assign lat_in = $signed(s_tdata[LAT_W-1:0]);
    assign lon_in = $signed(s_tdata[LAT_W+LON_W-1:LAT_W]);

    // A stage may load when it is empty or its item moves on in the same cycle.
    always_comb begin
        adv[AXIS_STAGES] = !m_tvalid_reg || m_tready;
        for (int i = AXIS_STAGES - 1; i >= 0; i--) begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
        ctrl.load  = adv[AXIS_STAGES-1:0];
        valid_next = {valid_reg[AXIS_STAGES-2:0], s_tvalid};
    end

    assign s_tready = adv[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            for (int i = 0; i < AXIS_STAGES; i++) begin
                if (adv[i]) begin
                    valid_reg[i] <= valid_next[i];
                end
            end
            if (adv[AXIS_STAGES]) begin
                m_tvalid_reg <= m_tvalid_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            prec_reg[0] <= s_tdata[LAT_W+LON_W+PREC_W-1:LAT_W+LON_W];
        end
        for (int i = 1; i < AXIS_STAGES; i++) begin
            if (adv[i]) begin
                prec_reg[i] <= prec_reg[i-1];
            end
        end
        if (adv[AXIS_STAGES]) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    mhl_axis_split #(
        .POS_W  (LAT_W),
        .SPAN   (LAT_SPAN),
        .SQUARE (LAT_SQUARE)
    ) u_lat_split (
        .aclk       (aclk),
        .ctrl       (ctrl),
        .pos        (lat_in),
        .coarse_idx (lat_coarse),
        .fine_idx   (lat_fine)
    );

    mhl_axis_split #(
        .POS_W  (LON_W),
        .SPAN   (LON_SPAN),
        .SQUARE (LON_SQUARE)
    ) u_lon_split (
        .aclk       (aclk),
        .ctrl       (ctrl),
        .pos        (lon_in),
        .coarse_idx (lon_coarse),
        .fine_idx   (lon_fine)
    );

    // Output stage: squares split into field and square, fine steps into
    // subsquare and extended square, then the precision masks apply.
    always_comb begin
        lat_cd = mhl_split10(lat_coarse);
        lon_cd = mhl_split10(lon_coarse);
        lat_fd = mhl_split10(lat_fine);
        lon_fd = mhl_split10(lon_fine);

        lon_field_letter     = ASCII_UPPER_A + 7'(lon_cd.tens);
        lat_field_letter     = ASCII_UPPER_A + 7'(lat_cd.tens);
        lon_square_digit     = ASCII_ZERO + 6'(lon_cd.ones);
        lat_square_digit     = ASCII_ZERO + 6'(lat_cd.ones);
        lon_subsquare_letter = '0;
        lat_subsquare_letter = '0;
        lon_extended_digit   = '0;
        lat_extended_digit   = '0;
        char_count           = COUNT_SHORT;

        if (prec_reg[AXIS_STAGES-1] >= PREC_SUB_MIN) begin
            lon_subsquare_letter = ASCII_LOWER_A + 7'(lon_fd.tens);
            lat_subsquare_letter = ASCII_LOWER_A + 7'(lat_fd.tens);
            char_count           = COUNT_MEDIUM;
        end
        if (prec_reg[AXIS_STAGES-1] >= PREC_EXT_MIN) begin
            lon_extended_digit = ASCII_ZERO + 6'(lon_fd.ones);
            lat_extended_digit = ASCII_ZERO + 6'(lat_fd.ones);
            char_count         = COUNT_FULL;
        end

        m_tdata_next  = {char_count, lat_extended_digit, lon_extended_digit,
                         lat_subsquare_letter, lon_subsquare_letter,
                         lat_square_digit, lon_square_digit,
                         lat_field_letter, lon_field_letter};
        m_tvalid_next = valid_reg[AXIS_STAGES-1];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `MHL_ASSERT_IMPL(a_count_legal, aclk, aresetn, m_tvalid, (m_tdata[55:52] == COUNT_SHORT || m_tdata[55:52] == COUNT_MEDIUM || m_tdata[55:52] == COUNT_FULL), "char_count is not 4, 6 or 8")
    `MHL_ASSERT_IMPL(a_field_range, aclk, aresetn, m_tvalid, (m_tdata[6:0] <= 7'd83 && m_tdata[13:7] <= 7'd83), "field letter beyond S")
    `MHL_ASSERT_IMPL(a_short_masked, aclk, aresetn, m_tvalid && m_tdata[55:52] == COUNT_SHORT, (m_tdata[51:26] == '0), "unused characters not zero at short precision")
    `MHL_ASSERT_IMPL(a_stall_full, aclk, aresetn, !s_tready, ((&valid_reg) && m_tvalid && !m_tready), "input stalled while the pipe has room")
    `MHL_ASSERT_NEXT(a_out_follows, aclk, aresetn, valid_reg[AXIS_STAGES-1] && adv[AXIS_STAGES], m_tvalid, "last stage item did not reach the output")

endmodule

>>> rtl/mhl_axis_split.sv
// Six-stage pipeline that splits one clamped axis into square and fine step indexes.
module mhl_axis_split import mhl_pkg::*; #(
    parameter int     POS_W  = LON_W,
    parameter longint SPAN   = LON_SPAN,
    parameter longint SQUARE = LON_SQUARE
) (
    input  logic                    aclk,
    input  mhl_pipe_ctrl_t          ctrl,
    input  logic signed [POS_W-1:0] pos,
    output logic [IDX_W-1:0]        coarse_idx,
    output logic [IDX_W-1:0]        fine_idx
);

    localparam int     U_W     = $clog2(2 * SPAN + 1);
    localparam int     Q_W     = $clog2(2 * SPAN / SQUARE + 1);
    localparam int     R_W     = $clog2(SQUARE);
    localparam int     V_W     = $clog2(FINE_DIV * SQUARE);
    localparam int     T_W     = $clog2(FINE_DIV);
    localparam longint RECIP_Q = (64'sd1 << U_W) / SQUARE;
    localparam longint RECIP_T = (64'sd1 << V_W) / SQUARE;
    localparam int     RQ_W    = $clog2(RECIP_Q + 1);
    localparam int     RT_W    = $clog2(RECIP_T + 1);
    localparam int     P1_W    = U_W + RQ_W;
    localparam int     P2_W    = V_W + RT_W;

    localparam logic signed [POS_W:0] SPAN_S = (POS_W + 1)'(SPAN);

    logic [U_W-1:0] u_reg, u_next, u2_reg;
    logic [Q_W-1:0] qe_reg, qe_next;
    logic [Q_W-1:0] q3_reg, q3_next, q4_reg, q5_reg, q6_reg;
    logic [R_W-1:0] r_reg, r_next;
    logic [V_W-1:0] v_reg, v_next, v5_reg;
    logic [T_W-1:0] te_reg, te_next;
    logic [T_W-1:0] t_reg, t_next;

    logic signed [POS_W:0] pos_ext, pos_clamp, pos_sum;
    logic [P1_W-1:0]       prod1, qe_full;
    logic [U_W-1:0]        qd, rem1;
    logic                  ge1;
    logic [P2_W-1:0]       prod2, te_full;
    logic [V_W-1:0]        td, rem2;
    logic                  ge2;

    // Stage 1: clamp to the legal span and move the origin to the lower edge.
    always_comb begin
        pos_ext = {pos[POS_W-1], pos};
        if (pos_ext > SPAN_S) begin
            pos_clamp = SPAN_S;
        end else if (pos_ext < -SPAN_S) begin
            pos_clamp = -SPAN_S;
        end else begin
            pos_clamp = pos_ext;
        end
        pos_sum = pos_clamp + SPAN_S;
        u_next  = pos_sum[U_W-1:0];
    end

    // Stage 2: reciprocal estimate of the square count, low by at most one.
    always_comb begin
        prod1   = P1_W'(u_reg) * P1_W'(RECIP_Q);
        qe_full = prod1 >> U_W;
        qe_next = qe_full[Q_W-1:0];
    end

    // Stage 3: fix the estimate and keep the remainder inside one square.
    always_comb begin
        qd      = U_W'(qe_reg) * U_W'(SQUARE);
        rem1    = u2_reg - qd;
        ge1     = (rem1 >= U_W'(SQUARE));
        q3_next = qe_reg + Q_W'(ge1);
        r_next  = ge1 ? R_W'(rem1 - U_W'(SQUARE)) : rem1[R_W-1:0];
    end

    // Stage 4: scale the remainder to subsquare times extended steps.
    always_comb begin
        v_next = V_W'(r_reg) * V_W'(FINE_DIV);
    end

    // Stage 5: reciprocal estimate of the fine step.
    always_comb begin
        prod2   = P2_W'(v_reg) * P2_W'(RECIP_T);
        te_full = prod2 >> V_W;
        te_next = te_full[T_W-1:0];
    end

    // Stage 6: fix the fine step estimate.
    always_comb begin
        td     = V_W'(te_reg) * V_W'(SQUARE);
        rem2   = v5_reg - td;
        ge2    = (rem2 >= V_W'(SQUARE));
        t_next = te_reg + T_W'(ge2);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[0]) begin
            u_reg <= u_next;
        end
        if (ctrl.load[1]) begin
            qe_reg <= qe_next;
            u2_reg <= u_reg;
        end
        if (ctrl.load[2]) begin
            q3_reg <= q3_next;
            r_reg  <= r_next;
        end
        if (ctrl.load[3]) begin
            q4_reg <= q3_reg;
            v_reg  <= v_next;
        end
        if (ctrl.load[4]) begin
            q5_reg <= q4_reg;
            v5_reg <= v_reg;
            te_reg <= te_next;
        end
        if (ctrl.load[5]) begin
            q6_reg <= q5_reg;
            t_reg  <= t_next;
        end
    end

    assign coarse_idx = IDX_W'(q6_reg);
    assign fine_idx   = IDX_W'(t_reg);

endmodule
